// ===== rtl/ptt_pkg.sv =====
// shared constants and types for the periodic task timer table
`default_nettype none

package ptt_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int TIME_BITS   = 16;
  localparam int SLOT_BITS   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int OP_BITS     = 2;
  localparam int INDEX_BITS  = 3;
  localparam int ARG_BITS    = 16;
  localparam int DELAY_BITS  = 15;
  localparam int PERIOD_BITS = 15;

  localparam int IN_FIELD_BITS  = INDEX_BITS + ARG_BITS + DELAY_BITS + PERIOD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = INDEX_BITS + ARG_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK     = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CANCEL   = 2'd2,
    OP_NONE     = 2'd3
  } ptt_op_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_task_timer_table_unit.sv =====
// periodic task timer table: tick counter, per-slot due times and a serial slot scan
// schedule and cancel items: the exec state runs before the next item can be taken
// tick items: exec state, a scan of every slot and a flush state; unless it stalls,
// the scan visits one slot per cycle through a single comparator and a single adder
// results leave through an output register; the scan stalls only when a slot fires while
// both the held result and the output register are full
`default_nettype none

module periodic_task_timer_table_unit
  import ptt_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  // task_index [2:0], call_arg [18:3], delay [33:19], reload_period [48:34], zero fill
  input  wire [IN_DATA_BITS-1:0]  in_tdata,
  // op [1:0]
  input  wire [OP_BITS-1:0]       in_tuser,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  // fired_task [2:0], fired_arg [18:3], zero fill
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                    out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                 state_r;
  logic [TIME_BITS-1:0]   now_r;
  logic [TIME_BITS-1:0]   due_r [TASK_SLOTS];
  logic [PERIOD_BITS-1:0] period_r [TASK_SLOTS];
  logic [ARG_BITS-1:0]    arg_r [TASK_SLOTS];
  logic [SLOT_BITS-1:0]   scan_r;

  // latched input item
  logic [OP_BITS-1:0]     op_r;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [ARG_BITS-1:0]    targ_r;
  logic [DELAY_BITS-1:0]  delay_r;
  logic [PERIOD_BITS-1:0] reload_r;

  // one fired slot held back until we know whether it is the last of the tick
  logic                   pend_v_r;
  logic [SLOT_BITS-1:0]   pend_task_r;
  logic [ARG_BITS-1:0]    pend_arg_r;

  logic                   out_valid_r;
  logic [INDEX_BITS-1:0]  out_task_r;
  logic [ARG_BITS-1:0]    out_arg_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   out_free;
  logic [TIME_BITS-1:0]   now_eff;
  logic [TIME_BITS-1:0]   add_b;
  logic [TIME_BITS-1:0]   sum;
  logic                   hit;
  logic                   stall;
  logic                   slot_ok;
  logic [SLOT_BITS-1:0]   slot_sel;
  logic [DELAY_BITS-1:0]  delay_eff;
  logic                   push_mid;
  logic                   push_end;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}}, out_arg_r, out_task_r};

  assign now_eff   = (now_r == '0) ? TIME_BITS'(1) : now_r;
  assign delay_eff = (delay_r == '0) ? DELAY_BITS'(1) : delay_r;
  assign slot_ok   = (int'(idx_r) < TASK_SLOTS);
  assign slot_sel  = SLOT_BITS'(idx_r);

  // shared adder: schedule due time, reload due time, tick advance
  always_comb begin
    case (state_r)
      ST_EXEC:  add_b = TIME_BITS'(delay_eff);
      ST_SCAN:  add_b = TIME_BITS'(period_r[scan_r]);
      ST_FLUSH: add_b = TIME_BITS'(1);
      default:  add_b = '0;
    endcase
  end

  assign sum   = TIME_BITS'(now_eff + add_b);
  assign hit   = (due_r[scan_r] == now_r);
  assign stall = hit && pend_v_r && !out_free;

  // held result moves to the output register mid-scan or as the last of the tick
  assign push_mid = (state_r == ST_SCAN) && hit && pend_v_r && out_free;
  assign push_end = (state_r == ST_FLUSH) && pend_v_r && out_free;

  // item latch, argument / period stores and held result fields, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_tuser;
      idx_r    <= in_tdata[INDEX_BITS-1:0];
      targ_r   <= in_tdata[INDEX_BITS +: ARG_BITS];
      delay_r  <= in_tdata[INDEX_BITS+ARG_BITS +: DELAY_BITS];
      reload_r <= in_tdata[INDEX_BITS+ARG_BITS+DELAY_BITS +: PERIOD_BITS];
    end
    if (state_r == ST_EXEC && ptt_op_t'(op_r) == OP_SCHEDULE && slot_ok) begin
      arg_r[slot_sel]    <= targ_r;
      period_r[slot_sel] <= reload_r;
    end
    if (state_r == ST_SCAN && hit && !stall) begin
      pend_task_r <= scan_r;
      pend_arg_r  <= arg_r[scan_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      scan_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_task_r  <= '0;
      out_arg_r   <= '0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        due_r[i] <= '0;
      end
    end else begin
      if (push_mid || push_end) begin
        out_valid_r <= 1'b1;
        out_task_r  <= INDEX_BITS'(pend_task_r);
        out_arg_r   <= pend_arg_r;
        out_last_r  <= push_end;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= (ptt_op_t'(op_r) == OP_TICK) ? ST_SCAN : ST_IDLE;
          case (ptt_op_t'(op_r))
            OP_TICK: begin
              now_r  <= now_eff;
              scan_r <= '0;
            end
            OP_SCHEDULE: begin
              now_r <= now_eff;
              if (slot_ok) begin
                due_r[slot_sel] <= sum;
              end
            end
            OP_CANCEL: begin
              if (slot_ok) begin
                due_r[slot_sel] <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (!stall) begin
            if (hit) begin
              due_r[scan_r] <= (period_r[scan_r] != '0) ? sum : '0;
              pend_v_r      <= 1'b1;
            end
            if (scan_r == SLOT_BITS'(TASK_SLOTS - 1)) begin
              state_r <= ST_FLUSH;
            end else begin
              scan_r <= SLOT_BITS'(scan_r + 1'b1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_r || out_free) begin
            pend_v_r <= 1'b0;
            now_r    <= sum;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/ptt_fire_checker.sv =====
// checker for the periodic task timer table: predicts firings from accepted items and compares
`timescale 1ns / 100ps

module ptt_fire_checker
  import ptt_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  input  wire                     in_tready,
  // task_index, call_arg, delay, reload_period, zero fill
  input  wire [IN_DATA_BITS-1:0]  in_tdata,
  // op
  input  wire [OP_BITS-1:0]       in_tuser,
  input  wire                     out_tvalid,
  input  wire                     out_tready,
  // fired_task, fired_arg, zero fill
  input  wire [OUT_DATA_BITS-1:0] out_tdata,
  input  wire                     out_tlast,
  output int                      mismatches,
  output int                      firings_owed
);

  localparam int ARG_LSB    = INDEX_BITS;
  localparam int DELAY_LSB  = ARG_LSB + ARG_BITS;
  localparam int PERIOD_LSB = DELAY_LSB + DELAY_BITS;

  typedef struct packed {
    logic [INDEX_BITS-1:0] slot;
    logic [ARG_BITS-1:0]   arg;
    logic                  last;
  } firing_t;

  logic [TIME_BITS-1:0]   tick_now;
  logic [TIME_BITS-1:0]   due_at    [TASK_SLOTS];
  logic [PERIOD_BITS-1:0] reload_of [TASK_SLOTS];
  logic [ARG_BITS-1:0]    arg_of    [TASK_SLOTS];
  firing_t                owed_q    [$];

  // apply one item to the timer table and queue the firings it causes
  task automatic advance_timer_table(input ptt_op_t op, input logic [INDEX_BITS-1:0] slot,
                                     input logic [ARG_BITS-1:0] arg,
                                     input logic [DELAY_BITS-1:0] dly,
                                     input logic [PERIOD_BITS-1:0] per);
    firing_t held;
    bit      have;
    have = 1'b0;
    held = '0;
    case (op)
      OP_TICK: begin
        if (tick_now == '0) tick_now = TIME_BITS'(1);
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (due_at[s] == tick_now) begin
            if (have) owed_q.push_back(held);
            held.slot = INDEX_BITS'(s);
            held.arg  = arg_of[s];
            held.last = 1'b0;
            have = 1'b1;
            // a reload that wraps to zero leaves the slot idle by itself
            due_at[s] = (reload_of[s] != '0) ? tick_now + reload_of[s] : '0;
          end
        end
        if (have) begin
          held.last = 1'b1;
          owed_q.push_back(held);
        end
        tick_now = tick_now + 1'b1;
      end
      OP_SCHEDULE: begin
        if (tick_now == '0) tick_now = TIME_BITS'(1);
        due_at[slot]    = tick_now + ((dly == '0) ? TIME_BITS'(1) : TIME_BITS'(dly));
        reload_of[slot] = per;
        arg_of[slot]    = arg;
      end
      OP_CANCEL: begin
        due_at[slot] = '0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    firing_t               want;
    logic [INDEX_BITS-1:0] got_slot;
    logic [ARG_BITS-1:0]   got_arg;
    if (!rst_n) begin
      tick_now = '0;
      for (int s = 0; s < TASK_SLOTS; s++) due_at[s] = '0;
      owed_q.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_slot = out_tdata[INDEX_BITS-1:0];
        got_arg  = out_tdata[ARG_LSB +: ARG_BITS];
        if (owed_q.size() == 0) begin
          $error("result with no firing owed: fired_task %0d fired_arg %0d",
                 got_slot, $signed(got_arg));
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (got_slot !== want.slot) begin
            $error("fired_task: expected %0d, got %0d", want.slot, got_slot);
            mismatches++;
          end
          if (got_arg !== want.arg) begin
            $error("fired_arg: expected %0d, got %0d", $signed(want.arg), $signed(got_arg));
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_timer_table(ptt_op_t'(in_tuser), in_tdata[INDEX_BITS-1:0],
                            in_tdata[ARG_LSB +: ARG_BITS], in_tdata[DELAY_LSB +: DELAY_BITS],
                            in_tdata[PERIOD_LSB +: PERIOD_BITS]);
      end
    end
    firings_owed = owed_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the timer table testbench: clock, reset, item stimulus, stalls and the verdict
`timescale 1ns / 100ps

module tb_top;
  import ptt_pkg::*;

  localparam int ARG_LSB    = INDEX_BITS;
  localparam int DELAY_LSB  = ARG_LSB + ARG_BITS;
  localparam int PERIOD_LSB = DELAY_LSB + DELAY_BITS;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic [OP_BITS-1:0]       in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  int                       mismatches;
  int                       firings_owed;
  logic                     stall_free;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  periodic_task_timer_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ptt_fire_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .firings_owed (firings_owed)
  );

  always @(posedge clk) begin
    out_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // offer one item, with random idle cycles ahead of it, and wait until it is taken
  task automatic send_item(input ptt_op_t op, input int idx, input int arg, input int dly,
                           input int per);
    logic [IN_DATA_BITS-1:0] word;
    word = '0;
    word[INDEX_BITS-1:0]           = idx[INDEX_BITS-1:0];
    word[ARG_LSB +: ARG_BITS]       = arg[ARG_BITS-1:0];
    word[DELAY_LSB +: DELAY_BITS]   = dly[DELAY_BITS-1:0];
    word[PERIOD_LSB +: PERIOD_BITS] = per[PERIOD_BITS-1:0];
    while (!stall_free && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    #200_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int counted;
    int pick;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_TICK;
    stall_free = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // first item is a schedule, which moves the zero tick count to one
    send_item(OP_SCHEDULE, 0, -32768, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_SCHEDULE, 7, 32767, 32767, 32767);
    send_item(OP_CANCEL, 7, 0, 0, 0);
    send_item(OP_CANCEL, 3, 0, 0, 0);
    send_item(OP_NONE, 7, -1, 32767, 32767);
    // every slot due on the same tick, periods of none, one and two
    for (int s = 0; s < TASK_SLOTS; s++) send_item(OP_SCHEDULE, s, 'h1111 * s - 5, 1, s % 3);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_CANCEL, 1, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);

    counted = 0;
    while (counted < 120) begin
      stall_free <= (counted >= 70 && counted < 100);
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(OP_TICK, $urandom_range(7), $urandom_range(65535), $urandom_range(32767),
                  $urandom_range(32767));
        counted++;
      end else if (pick < 80) begin
        send_item(OP_SCHEDULE, $urandom_range(7), $urandom_range(65535),
                  ($urandom_range(99) < 80) ? $urandom_range(6) : $urandom_range(32767),
                  ($urandom_range(99) < 40) ? 0 :
                  (($urandom_range(99) < 75) ? $urandom_range(1, 8) : $urandom_range(32767)));
        counted++;
      end else if (pick < 93) begin
        send_item(OP_CANCEL, $urandom_range(7), $urandom_range(65535), $urandom_range(32767),
                  $urandom_range(32767));
        counted++;
      end else begin
        send_item(OP_NONE, $urandom_range(7), $urandom_range(65535), $urandom_range(32767),
                  $urandom_range(32767));
      end
    end

    in_tvalid <= 1'b0;
    stall_free <= 1'b0;

    repeat (2) @(posedge clk);
    wait (firings_owed == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && firings_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptt_pkg.sv
rtl/periodic_task_timer_table_unit.sv
tb/ptt_fire_checker.sv
tb/tb_top.sv
